/* rtl/bounded_history_cursor_store_unit_macros.svh */
// Assertion helpers for the module that checks its own logic.
`ifndef BOUNDED_HISTORY_CURSOR_STORE_UNIT_MACROS_SVH
`define BOUNDED_HISTORY_CURSOR_STORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bhcs_pkg.sv */
package bhcs_pkg;

    // Request codes.
    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_BACK    = 3'd1;
    localparam logic [2:0] REQ_FORWARD = 3'd2;
    localparam logic [2:0] REQ_READ    = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // Field widths.
    localparam int REQ_W   = 3;
    localparam int EP_W    = 8;
    localparam int ARG_W   = 64;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Register port.
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int MAX_W   = 5;
    localparam logic [APB_AW-3:0] REG_MAX_ENTRIES = 1'd0;
    localparam logic [MAX_W-1:0]  MAX_ENTRIES_RST = 5'd16;

    typedef struct packed {
        logic [EP_W-1:0]  endpoint;
        logic [ARG_W-1:0] user_id;
        logic [ARG_W-1:0] arg_first;
        logic [ARG_W-1:0] arg_second;
        logic [ARG_W-1:0] text_ref;
    } t_record;

endpackage

/* rtl/bhcs_ifs.sv */
interface bhcs_req_if;
    logic                        valid;
    logic                        ready;
    logic [bhcs_pkg::REQ_W-1:0]  req_type;
    logic [bhcs_pkg::EP_W-1:0]   endpoint;
    logic [bhcs_pkg::ARG_W-1:0]  user_id;
    logic [bhcs_pkg::ARG_W-1:0]  arg_first;
    logic [bhcs_pkg::ARG_W-1:0]  arg_second;
    logic [bhcs_pkg::ARG_W-1:0]  text_ref;

    modport source (
        output valid, req_type, endpoint, user_id, arg_first, arg_second, text_ref,
        input  ready
    );
    modport sink (
        input  valid, req_type, endpoint, user_id, arg_first, arg_second, text_ref,
        output ready
    );
endinterface

interface bhcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [bhcs_pkg::EP_W-1:0]     out_endpoint;
    logic [bhcs_pkg::ARG_W-1:0]    out_user_id;
    logic [bhcs_pkg::ARG_W-1:0]    out_arg_first;
    logic [bhcs_pkg::ARG_W-1:0]    out_arg_second;
    logic [bhcs_pkg::ARG_W-1:0]    out_text_ref;
    logic [bhcs_pkg::POS_W-1:0]    cursor_pos;
    logic [bhcs_pkg::COUNT_W-1:0]  entry_count;

    modport source (
        output valid, hit, out_endpoint, out_user_id, out_arg_first, out_arg_second,
               out_text_ref, cursor_pos, entry_count,
        input  ready
    );
    modport sink (
        input  valid, hit, out_endpoint, out_user_id, out_arg_first, out_arg_second,
               out_text_ref, cursor_pos, entry_count,
        output ready
    );
endinterface

/* rtl/bounded_history_cursor_store_unit.sv */
// Bounded back/forward history of request records. Every item on i_req carries one request:
// push a record, step the cursor back or forward, read the record under the cursor, or clear.
// A push drops the records after the cursor, evicts the oldest ones if the store would exceed
// the bound held in the max_entries register (0 acts as 1, values above HISTORY_DEPTH act as
// HISTORY_DEPTH), appends the record and puts the cursor on it. Each item gives exactly one
// result item on o_rsp, in the cycle after it is accepted, with hit, the selected record (all
// zero on a miss), the cursor position and the record count. The block takes one item in
// every cycle: the whole request is a pointer update plus a single write or a single read of
// the record memory, so the one-port-write, one-port-read memory sets the figure of one item
// per cycle. While a result waits on o_rsp the input stalls; a new item is taken in the same
// cycle as the waiting result leaves. Slots that were never written are never selected, so
// the memory needs no clearing after reset.
// max_entries is register 0 at byte address 0 and should be written only while idle.
module bounded_history_cursor_store_unit #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bhcs_req_if.sink                       i_req,
    bhcs_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bhcs_pkg::APB_AW-1:0]    paddr,
    input  logic [bhcs_pkg::APB_DW-1:0]    pwdata,
    output logic [bhcs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    // Slot and cursor width, and record count width.
    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    // Width of the ring sums, wide enough to hold twice the depth.
    localparam int SW = CW + 1;
    // Width used to compare the raw bound against the depth.
    localparam int XW = (SW > bhcs_pkg::MAX_W) ? SW : bhcs_pkg::MAX_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);
    localparam logic [XW-1:0] DEPTH_X = XW'(HISTORY_DEPTH);

    // Control state.
    logic [PW-1:0]                  r_oldest;
    logic [CW-1:0]                  r_count;
    logic [PW-1:0]                  r_cursor;
    logic [bhcs_pkg::MAX_W-1:0]     r_max_entries;
    logic                           r_out_valid;

    // Result register.
    logic                           r_res_hit;
    logic [PW-1:0]                  r_res_cursor;
    logic [CW-1:0]                  r_res_count;
    bhcs_pkg::t_record              r_res_rec;

    // Record memory.
    bhcs_pkg::t_record              r_mem [HISTORY_DEPTH];

    logic [PW-1:0]                  n_oldest;
    logic [CW-1:0]                  n_count;
    logic [PW-1:0]                  n_cursor;
    logic                           n_hit;

    logic                           accept;
    logic                           is_push;
    logic                           cfg_write;
    bhcs_pkg::t_record              in_rec;

    logic [XW-1:0]                  max_x;
    logic [XW-1:0]                  bound_x;
    logic [CW-1:0]                  bound;
    logic [SW-1:0]                  cur_plus1;
    logic                           cur_before_end;
    logic [CW-1:0]                  trunc_count;
    logic [CW-1:0]                  drop;
    logic [SW-1:0]                  evict_sum;
    logic [PW-1:0]                  push_oldest;
    logic [CW-1:0]                  push_held;
    logic [SW-1:0]                  wr_sum;
    logic [PW-1:0]                  wr_slot;
    logic [SW-1:0]                  rd_sum;
    logic [PW-1:0]                  rd_slot;
    logic [PW+bhcs_pkg::POS_W-1:0]  cursor_wide;
    logic [CW+bhcs_pkg::COUNT_W-1:0] count_wide;

    // Handshakes. The result register frees up when its item is taken.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_push     = (i_req.req_type == bhcs_pkg::REQ_PUSH);

    assign in_rec.endpoint   = i_req.endpoint;
    assign in_rec.user_id    = i_req.user_id;
    assign in_rec.arg_first  = i_req.arg_first;
    assign in_rec.arg_second = i_req.arg_second;
    assign in_rec.text_ref   = i_req.text_ref;

    // Register port: one register, always ready.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[bhcs_pkg::APB_AW-1:2] == bhcs_pkg::REG_MAX_ENTRIES);
    assign prdata    = (paddr[bhcs_pkg::APB_AW-1:2] == bhcs_pkg::REG_MAX_ENTRIES)
                       ? {{(bhcs_pkg::APB_DW - bhcs_pkg::MAX_W){1'b0}}, r_max_entries} : '0;

    // Effective bound, clamped to one through the depth.
    always_comb begin
        max_x = XW'(r_max_entries);
        if (max_x == '0) begin
            bound_x = XW'(1);
        end else if (max_x > DEPTH_X) begin
            bound_x = DEPTH_X;
        end else begin
            bound_x = max_x;
        end
        bound = CW'(bound_x);
    end

    // Push path: truncate after the cursor, evict the oldest records if needed,
    // then find the slot of the new record.
    always_comb begin
        cur_plus1      = SW'(r_cursor) + SW'(1);
        cur_before_end = cur_plus1 < SW'(r_count);
        trunc_count    = (r_count != '0 && cur_before_end) ? CW'(cur_plus1) : r_count;
        drop           = trunc_count - bound + CW'(1);
        evict_sum      = SW'(r_oldest) + SW'(drop);
        if (trunc_count >= bound) begin
            push_oldest = (evict_sum >= DEPTH_S) ? PW'(evict_sum - DEPTH_S) : PW'(evict_sum);
            push_held   = bound - CW'(1);
        end else begin
            push_oldest = r_oldest;
            push_held   = trunc_count;
        end
        wr_sum  = SW'(push_oldest) + SW'(push_held);
        wr_slot = (wr_sum >= DEPTH_S) ? PW'(wr_sum - DEPTH_S) : PW'(wr_sum);
    end

    // Next state for each request.
    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_hit    = 1'b0;
        case (i_req.req_type)
            bhcs_pkg::REQ_PUSH: begin
                n_oldest = push_oldest;
                n_count  = push_held + CW'(1);
                n_cursor = PW'(push_held);
                n_hit    = 1'b1;
            end
            bhcs_pkg::REQ_BACK: begin
                if (r_count != '0 && r_cursor != '0) begin
                    n_cursor = r_cursor - PW'(1);
                    n_hit    = 1'b1;
                end
            end
            bhcs_pkg::REQ_FORWARD: begin
                if (cur_before_end) begin
                    n_cursor = PW'(cur_plus1);
                    n_hit    = 1'b1;
                end
            end
            bhcs_pkg::REQ_READ: begin
                n_hit = (r_count != '0);
            end
            bhcs_pkg::REQ_CLEAR: begin
                n_oldest = '0;
                n_count  = '0;
                n_cursor = '0;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    // Slot under the cursor after the move, for the non-push requests.
    always_comb begin
        rd_sum  = SW'(r_oldest) + SW'(n_cursor);
        rd_slot = (rd_sum >= DEPTH_S) ? PW'(rd_sum - DEPTH_S) : PW'(rd_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest      <= '0;
            r_count       <= '0;
            r_cursor      <= '0;
            r_max_entries <= bhcs_pkg::MAX_ENTRIES_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_max_entries <= pwdata[bhcs_pkg::MAX_W-1:0];
            end
            if (accept) begin
                r_oldest    <= n_oldest;
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A push returns the record it writes; other requests read the memory.
    always_ff @(posedge i_clk) begin
        if (accept && is_push) begin
            r_mem[wr_slot] <= in_rec;
        end
        if (accept) begin
            r_res_hit    <= n_hit;
            r_res_cursor <= n_cursor;
            r_res_count  <= n_count;
            r_res_rec    <= is_push ? in_rec : r_mem[rd_slot];
        end
    end

    assign cursor_wide = (PW + bhcs_pkg::POS_W)'(r_res_cursor);
    assign count_wide  = (CW + bhcs_pkg::COUNT_W)'(r_res_count);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.hit            = r_res_hit;
    assign o_rsp.out_endpoint   = r_res_hit ? r_res_rec.endpoint   : '0;
    assign o_rsp.out_user_id    = r_res_hit ? r_res_rec.user_id    : '0;
    assign o_rsp.out_arg_first  = r_res_hit ? r_res_rec.arg_first  : '0;
    assign o_rsp.out_arg_second = r_res_hit ? r_res_rec.arg_second : '0;
    assign o_rsp.out_text_ref   = r_res_hit ? r_res_rec.text_ref   : '0;
    assign o_rsp.cursor_pos     = cursor_wide[bhcs_pkg::POS_W-1:0];
    assign o_rsp.entry_count    = count_wide[bhcs_pkg::COUNT_W-1:0];

`include "bounded_history_cursor_store_unit_macros.svh"

    // An empty store keeps the cursor at zero.
    `BHCS_ASSERT_SAME(a_empty_cursor_zero, i_clk, i_rst_n, r_count == '0, r_cursor == '0, "cursor moved in an empty store")
    // A non-empty store keeps the cursor on a held record.
    `BHCS_ASSERT_SAME(a_cursor_in_range, i_clk, i_rst_n, r_count != '0, SW'(r_cursor) < SW'(r_count), "cursor beyond the held records")
    // A push always gives a hit with the cursor on the newest record.
    `BHCS_ASSERT_NEXT(a_push_hits, i_clk, i_rst_n, accept && is_push, r_out_valid && r_res_hit && (SW'(r_res_cursor) + SW'(1) == SW'(r_res_count)), "push did not land on the newest record")

endmodule

/* bench/tb_bounded_history_cursor_store_unit.sv */
module tb_bounded_history_cursor_store_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The history ring of the block under test is built with this many slots.
    localparam int DEPTH   = 16;
    localparam int DEPTH_W = $clog2(DEPTH);

    // Each side idles with roughly this chance, in percent.
    localparam int IDLE_PCT = 6;

    // Request codes 5 to 7 are undefined. The block must ignore them and answer with a miss.
    localparam logic [bhcs_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [bhcs_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

    // Byte address of max_entries on the register port.
    localparam logic [bhcs_pkg::APB_AW-1:0] ADDR_MAX_ENTRIES =
        {bhcs_pkg::REG_MAX_ENTRIES, 2'b00};

    // One request item as the stimulus side sees it.
    typedef struct {
        logic [bhcs_pkg::REQ_W-1:0] kind;
        bhcs_pkg::t_record          rec;
    } t_hist_req;

    // One result item: the record under the cursor (zero on a miss) and the ring status.
    typedef struct {
        logic                         hit;
        bhcs_pkg::t_record            rec;
        logic [bhcs_pkg::POS_W-1:0]   cursor_pos;
        logic [bhcs_pkg::COUNT_W-1:0] entry_count;
    } t_hist_view;

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bhcs_pkg::APB_AW-1:0] paddr;
    logic [bhcs_pkg::APB_DW-1:0] pwdata;
    logic [bhcs_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    bhcs_req_if req_bus ();
    bhcs_rsp_if rsp_bus ();

    bounded_history_cursor_store_unit #(
        .HISTORY_DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Shadow copy of the history ring. The slots are addressed the same way as in the block:
    // position p counted from the oldest record lives in slot (ring_oldest + p) mod DEPTH.
    bhcs_pkg::t_record          ring_mem [DEPTH];
    int unsigned                ring_oldest = 0;
    int unsigned                ring_held   = 0;
    int unsigned                ring_cursor = 0;
    logic [bhcs_pkg::MAX_W-1:0] bound_reg   = bhcs_pkg::MAX_ENTRIES_RST;

    // Results that the block still owes, oldest first.
    t_hist_view expected_views[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    // Cleared for one stretch of the random traffic so that both sides run flat out there.
    bit idle_on = 1'b1;

    // Applies one accepted request to the shadow ring and returns the result it must give.
    function automatic t_hist_view history_apply(input t_hist_req r);
        int unsigned bound;
        int unsigned drop;
        logic        hit;
        t_hist_view  v;
        hit = 1'b0;
        // A bound of zero behaves as one, anything above the ring size as the ring size.
        if (bound_reg == '0) begin
            bound = 1;
        end else if (bound_reg > DEPTH) begin
            bound = DEPTH;
        end else begin
            bound = 32'(bound_reg);
        end
        case (r.kind)
            bhcs_pkg::REQ_PUSH: begin
                // Everything newer than the cursor is forgotten first.
                if (ring_held > 0 && ring_cursor + 1 < ring_held) begin
                    ring_held = ring_cursor + 1;
                end
                // Then the oldest records go until the new one fits. After the bound has
                // been lowered this may drop several records at once.
                if (ring_held >= bound) begin
                    drop        = ring_held - bound + 1;
                    ring_oldest = (ring_oldest + drop) % DEPTH;
                    ring_held   = ring_held - drop;
                end
                ring_mem[DEPTH_W'((ring_oldest + ring_held) % DEPTH)] = r.rec;
                ring_held   = ring_held + 1;
                ring_cursor = ring_held - 1;
                hit         = 1'b1;
            end
            bhcs_pkg::REQ_BACK: begin
                if (ring_held > 0 && ring_cursor > 0) begin
                    ring_cursor = ring_cursor - 1;
                    hit         = 1'b1;
                end
            end
            bhcs_pkg::REQ_FORWARD: begin
                if (ring_cursor + 1 < ring_held) begin
                    ring_cursor = ring_cursor + 1;
                    hit         = 1'b1;
                end
            end
            bhcs_pkg::REQ_READ: begin
                hit = (ring_held > 0);
            end
            bhcs_pkg::REQ_CLEAR: begin
                // Clearing also puts the cursor and the oldest slot back to zero.
                ring_held   = 0;
                ring_cursor = 0;
                ring_oldest = 0;
            end
            default: begin
                // Undefined codes leave the ring alone and answer with a miss.
            end
        endcase
        v.hit         = hit;
        v.rec         = hit ? ring_mem[DEPTH_W'((ring_oldest + ring_cursor) % DEPTH)] : '0;
        v.cursor_pos  = ring_cursor[bhcs_pkg::POS_W-1:0];
        v.entry_count = ring_held[bhcs_pkg::COUNT_W-1:0];
        return v;
    endfunction

    // Mostly random records, with the all-zero and all-one patterns and a missing text
    // handle mixed in now and then.
    function automatic bhcs_pkg::t_record random_record();
        bhcs_pkg::t_record rec;
        int unsigned       shape;
        logic [31:0]       word;
        shape = $urandom_range(0, 9);
        word  = $urandom;
        if (shape == 0) begin
            rec = '0;
        end else if (shape == 1) begin
            rec = '1;
        end else begin
            rec.endpoint   = word[bhcs_pkg::EP_W-1:0];
            rec.user_id    = {$urandom, $urandom};
            rec.arg_first  = {$urandom, $urandom};
            rec.arg_second = {$urandom, $urandom};
            rec.text_ref   = (shape == 2) ? '0 : {$urandom, $urandom};
        end
        return rec;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] result %0d: %s is %h, predicted %h",
                 $realtime, results_seen, what, got, want);
    endtask

    // Presents one request item, holds it until the block takes it, and predicts its result.
    // The request is driven at a falling edge and counted as taken at the rising edge where
    // ready is seen high.
    task automatic send_request(input logic [bhcs_pkg::REQ_W-1:0] kind,
                                input bhcs_pkg::t_record rec);
        t_hist_req r;
        r.kind = kind;
        r.rec  = rec;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.endpoint   <= rec.endpoint;
        req_bus.user_id    <= rec.user_id;
        req_bus.arg_first  <= rec.arg_first;
        req_bus.arg_second <= rec.arg_second;
        req_bus.text_ref   <= rec.text_ref;
        @(posedge clk);
        while (req_bus.ready !== 1'b1) @(posedge clk);
        expected_views.insert(expected_views.size(), history_apply(r));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_views.size() != 0) @(posedge clk);
    endtask

    // Writes max_entries while the block is idle and reads it back.
    task automatic write_max_entries(input logic [bhcs_pkg::MAX_W-1:0] value);
        stop_sending();
        wait_drained();
        // Let the last result leave and the block settle before the write.
        repeat (2) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_ENTRIES;
        pwdata  <= {{(bhcs_pkg::APB_DW - bhcs_pkg::MAX_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        bound_reg = value;
        // Go straight into the setup cycle of the read-back.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        if (prdata[bhcs_pkg::MAX_W-1:0] !== value) begin
            report_mismatch("max_entries read back", 64'(prdata), 64'(value));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Back, forward and read on an empty store all miss; clear and the undefined codes miss.
    task automatic test_empty_requests();
        send_request(bhcs_pkg::REQ_BACK, random_record());
        send_request(bhcs_pkg::REQ_FORWARD, random_record());
        send_request(bhcs_pkg::REQ_READ, random_record());
        send_request(bhcs_pkg::REQ_CLEAR, random_record());
        for (int c = int'(REQ_UNUSED_FIRST); c <= int'(REQ_UNUSED_LAST); c++) begin
            send_request(c[bhcs_pkg::REQ_W-1:0], random_record());
        end
    endtask

    // Pushes the all-zero and all-one records, then walks into both ends of the history.
    task automatic test_push_and_walk();
        send_request(bhcs_pkg::REQ_PUSH, '0);
        send_request(bhcs_pkg::REQ_PUSH, '1);
        send_request(bhcs_pkg::REQ_BACK, random_record());
        send_request(bhcs_pkg::REQ_BACK, random_record());
        send_request(bhcs_pkg::REQ_FORWARD, random_record());
        send_request(bhcs_pkg::REQ_FORWARD, random_record());
        send_request(bhcs_pkg::REQ_READ, random_record());
    endtask

    // A push with the cursor on an older record must drop the newer one.
    task automatic test_truncating_push();
        send_request(bhcs_pkg::REQ_BACK, random_record());
        send_request(bhcs_pkg::REQ_PUSH, random_record());
        send_request(bhcs_pkg::REQ_READ, random_record());
        send_request(bhcs_pkg::REQ_FORWARD, random_record());
    endtask

    // A zero bound keeps one record, a small bound evicts the oldest, and lowering the bound
    // below the held count makes the next push drop several records at once.
    task automatic test_bound_extremes();
        write_max_entries(5'd0);
        send_request(bhcs_pkg::REQ_PUSH, random_record());
        send_request(bhcs_pkg::REQ_PUSH, random_record());
        write_max_entries(5'd2);
        repeat (3) send_request(bhcs_pkg::REQ_PUSH, random_record());
        write_max_entries(5'd1);
        send_request(bhcs_pkg::REQ_PUSH, random_record());
    endtask

    task automatic test_clear_history();
        send_request(bhcs_pkg::REQ_CLEAR, random_record());
        send_request(bhcs_pkg::REQ_READ, random_record());
        send_request(bhcs_pkg::REQ_PUSH, random_record());
    endtask

    // Random traffic built mostly from meaningful runs: bursts of pushes that fill the ring
    // and wrap it, walks back and forward across the history, and single requests of any
    // code in between. Undefined codes are sent as noise but not counted.
    task automatic run_history_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        int unsigned code;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                burst = $urandom_range(1, 20);
                repeat (burst) send_request(bhcs_pkg::REQ_PUSH, random_record());
                sent += burst;
            end else if (pick < 50) begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_request(bhcs_pkg::REQ_BACK, random_record());
                sent += burst;
            end else if (pick < 65) begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_request(bhcs_pkg::REQ_FORWARD, random_record());
                sent += burst;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_request(bhcs_pkg::REQ_READ, random_record());
                    sent++;
                end else if (pick < 50) begin
                    send_request(bhcs_pkg::REQ_CLEAR, random_record());
                    sent++;
                end else if (pick < 60) begin
                    code = $urandom_range(int'(REQ_UNUSED_FIRST), int'(REQ_UNUSED_LAST));
                    send_request(code[bhcs_pkg::REQ_W-1:0], random_record());
                end else if (pick < 75) begin
                    send_request(bhcs_pkg::REQ_PUSH, random_record());
                    sent++;
                end else if (pick < 88) begin
                    send_request(bhcs_pkg::REQ_BACK, random_record());
                    sent++;
                end else begin
                    send_request(bhcs_pkg::REQ_FORWARD, random_record());
                    sent++;
                end
            end
        end
    endtask

    // Eight phases of about 110 items, each under its own bound. The first phase keeps the
    // reset-sized bound and runs without any idling; one phase stops halfway until every
    // owed result has come back.
    task automatic test_random_traffic();
        logic [bhcs_pkg::MAX_W-1:0] bounds [8];
        int unsigned                pick_bound;
        bounds[0]  = 5'd16;
        bounds[1]  = 5'd31;
        pick_bound = $urandom_range(3, 15);
        bounds[2]  = pick_bound[bhcs_pkg::MAX_W-1:0];
        bounds[3]  = 5'd1;
        bounds[4]  = 5'd17;
        bounds[5]  = 5'd0;
        pick_bound = $urandom_range(2, 15);
        bounds[6]  = pick_bound[bhcs_pkg::MAX_W-1:0];
        bounds[7]  = 5'd16;
        for (int ph = 0; ph < 8; ph++) begin
            write_max_entries(bounds[ph]);
            idle_on = (ph != 0);
            if (ph == 2) begin
                run_history_phase(55);
                stop_sending();
                wait_drained();
                run_history_phase(55);
            end else begin
                run_history_phase(110);
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver: ready is held low now and then, chosen afresh at every falling edge.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Every result item taken at a rising edge is compared with the oldest prediction.
    always @(posedge clk) begin : check_views
        t_hist_view want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            results_seen++;
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result", 64'(rsp_bus.hit), 64'd0);
            end else begin
                want = expected_views.pop_front();
                if (rsp_bus.hit !== want.hit) begin
                    report_mismatch("hit", 64'(rsp_bus.hit), 64'(want.hit));
                end
                if (rsp_bus.out_endpoint !== want.rec.endpoint) begin
                    report_mismatch("out_endpoint", 64'(rsp_bus.out_endpoint),
                                    64'(want.rec.endpoint));
                end
                if (rsp_bus.out_user_id !== want.rec.user_id) begin
                    report_mismatch("out_user_id", rsp_bus.out_user_id, want.rec.user_id);
                end
                if (rsp_bus.out_arg_first !== want.rec.arg_first) begin
                    report_mismatch("out_arg_first", rsp_bus.out_arg_first, want.rec.arg_first);
                end
                if (rsp_bus.out_arg_second !== want.rec.arg_second) begin
                    report_mismatch("out_arg_second", rsp_bus.out_arg_second,
                                    want.rec.arg_second);
                end
                if (rsp_bus.out_text_ref !== want.rec.text_ref) begin
                    report_mismatch("out_text_ref", rsp_bus.out_text_ref, want.rec.text_ref);
                end
                if (rsp_bus.cursor_pos !== want.cursor_pos) begin
                    report_mismatch("cursor_pos", 64'(rsp_bus.cursor_pos), 64'(want.cursor_pos));
                end
                if (rsp_bus.entry_count !== want.entry_count) begin
                    report_mismatch("entry_count", 64'(rsp_bus.entry_count),
                                    64'(want.entry_count));
                end
            end
        end
    end

    // Main sequence: reset, directed checks, random traffic, then a bounded drain.
    initial begin : main_sequence
        int unsigned waited;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = bhcs_pkg::REQ_READ;
        req_bus.endpoint   = '0;
        req_bus.user_id    = '0;
        req_bus.arg_first  = '0;
        req_bus.arg_second = '0;
        req_bus.text_ref   = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_requests();
        test_push_and_walk();
        test_truncating_push();
        test_bound_extremes();
        test_clear_history();
        test_random_traffic();

        stop_sending();
        waited = 0;
        while (expected_views.size() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        // Go on waiting so that a stray extra result would still be caught.
        repeat (4) @(posedge clk);
        while (expected_views.size() != 0) begin
            void'(expected_views.pop_front());
            report_mismatch("result never arrived", 64'd0, 64'd0);
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: the time limit lies well beyond the whole run, so this only fires on a hang.
    initial begin
        #200_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
